// ===== rtl/mann_whitney_u_statistic_core_defines.svh =====
// assertion macros shared by the mann-whitney u core
// expects clk and rst_n in the scope where a macro is used
`ifndef MANN_WHITNEY_U_STATISTIC_CORE_DEFINES_SVH
`define MANN_WHITNEY_U_STATISTIC_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MWU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mwu assertion failed");

// next-cycle implication, disabled in reset
`define MWU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mwu assertion failed");

`endif

// ===== rtl/mwu_pkg.sv =====
// constants, token type and helpers for the mann-whitney u core
// no dependencies
package mwu_pkg;

    localparam int MAX_FIRST  = 64;
    localparam int MAX_SECOND = 64;

    // one cell per stored entry of the larger group
    localparam int CHAIN_LEN = (MAX_FIRST > MAX_SECOND) ? MAX_FIRST : MAX_SECOND;
    localparam int CNT_W     = $clog2(CHAIN_LEN + 1);

    localparam int VALUE_W = 32;
    localparam int SUM_W   = 14;
    localparam int SIZE_W  = 7;

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

    // pair scores, doubled
    localparam logic [1:0] SCORE_LESS    = 2'd0;
    localparam logic [1:0] SCORE_TIE     = 2'd1;
    localparam logic [1:0] SCORE_GREATER = 2'd2;

    // what travels from cell to cell with one observation
    typedef struct packed {
        logic               second;    // observation belongs to the second group
        logic [VALUE_W-1:0] key;       // raw observation
        logic [CNT_W-1:0]   opp_left;  // occupied opposite entries still ahead
        logic [CNT_W-1:0]   wr_left;   // cells to pass before the write slot
        logic               wr_done;   // observation already stored
        logic [SUM_W-1:0]   sum;       // running doubled u
    } token_t;

    function automatic logic [SIZE_W-1:0] sat_size(input logic [CNT_W-1:0] c);
        logic [SIZE_W-1:0] r;
        if (32'(c) > 32'(SIZE_MAX))
            r = SIZE_MAX;
        else
            r = SIZE_W'(c);
        return r;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [1:0] d);
        logic [SUM_W:0] t;
        t = {1'b0, s} + {{(SUM_W - 1){1'b0}}, d};
        return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
    endfunction

endpackage

// ===== rtl/mwu_sample_if.sv =====
// valid/ready channel carrying one observation per transaction
// depends on mwu_pkg
interface mwu_sample_if;
    logic                              valid;
    logic                              ready;
    logic signed [mwu_pkg::VALUE_W-1:0] sample_value;
    logic                              group;
    logic                              last;

    modport source (output valid, output sample_value, output group, output last,
                    input ready);
    modport sink   (input valid, input sample_value, input group, input last,
                    output ready);
endinterface

// ===== rtl/mwu_result_if.sv =====
// valid/ready channel carrying one statistic per transaction
// depends on mwu_pkg
interface mwu_result_if;
    logic                         valid;
    logic                         ready;
    logic [mwu_pkg::SUM_W-1:0]    u_doubled;
    logic [mwu_pkg::SIZE_W-1:0]   first_size;
    logic [mwu_pkg::SIZE_W-1:0]   second_size;
    logic                         overflow;

    modport source (output valid, output u_doubled, output first_size,
                    output second_size, output overflow, input ready);
    modport sink   (input valid, input u_doubled, input first_size,
                    input second_size, input overflow, output ready);
endinterface

// ===== rtl/mann_whitney_u_statistic_core.sv =====
// top level of the mann-whitney u statistic core
// depends on mwu_pkg, mwu_sample_if, mwu_result_if, mwu_cell and mwu_ctrl
//
// streams one data set of observations and returns twice the mann-whitney u
// statistic, both group sizes and an overflow flag. each accepted transaction
// on samples carries one observation, its group (0 first, 1 second) and a
// last mark. the observation is scored against every stored observation of
// the other group (first greater scores 2, a tie 1, else 0) and stored in its
// own group. up to 64 observations per group are kept; one beyond that is
// dropped, unscored, and sets overflow. the transaction marked last produces
// one transaction on results and clears the set. the observation travels
// down a row of 64 comparison cells, one cell per cycle, carrying the running
// sum, so samples is not ready again until the sum has left the last cell;
// a dropped one passes only the done state. a finished result sits in an
// output register and the next set's samples are taken while it waits;
// only a second result finishing before the first is taken holds the block.
// there is no clearing pass after reset.
module mann_whitney_u_statistic_core (
    input  logic          clk,
    input  logic          rst_n,
    mwu_sample_if.sink    samples,
    mwu_result_if.source  results
);

    // link k feeds cell k; link 0 comes from the controller, the last link
    // returns the finished sum
    logic            link_valid [mwu_pkg::CHAIN_LEN + 1];
    mwu_pkg::token_t link_tok   [mwu_pkg::CHAIN_LEN + 1];

    mwu_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .samples      (samples),
        .results      (results),
        .launch_valid (link_valid[0]),
        .launch_tok   (link_tok[0]),
        .exit_valid   (link_valid[mwu_pkg::CHAIN_LEN]),
        .exit_tok     (link_tok[mwu_pkg::CHAIN_LEN])
    );

    // row of comparison cells; cell k holds entry k of each group
    for (genvar k = 0; k < mwu_pkg::CHAIN_LEN; k++)
    begin : g_cell
        mwu_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .tok_valid_in  (link_valid[k]),
            .tok_in        (link_tok[k]),
            .tok_valid_out (link_valid[k + 1]),
            .tok_out       (link_tok[k + 1])
        );
    end

endmodule

// ===== rtl/mwu_cell.sv =====
// one comparison cell: holds one first and one second entry, scores the
// passing observation and stores it at its slot; depends on mwu_pkg
module mwu_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tok_valid_in,
    input  mwu_pkg::token_t tok_in,
    output logic            tok_valid_out,
    output mwu_pkg::token_t tok_out
);

    logic [mwu_pkg::VALUE_W-1:0] first_val_reg;
    logic [mwu_pkg::VALUE_W-1:0] second_val_reg;
    logic                        valid_reg;
    mwu_pkg::token_t             tok_reg;
    mwu_pkg::token_t             tok_next;
    logic [mwu_pkg::VALUE_W-1:0] a;
    logic [mwu_pkg::VALUE_W-1:0] b;
    logic [1:0]                  score;
    logic                        wr_here;

    always_comb
    begin
        // pair is always (first, second)
        a = tok_in.second ? first_val_reg : tok_in.key;
        b = tok_in.second ? tok_in.key : second_val_reg;
        if (tok_in.opp_left == '0)
            score = mwu_pkg::SCORE_LESS;
        else if ($signed(a) > $signed(b))
            score = mwu_pkg::SCORE_GREATER;
        else if (a == b)
            score = mwu_pkg::SCORE_TIE;
        else
            score = mwu_pkg::SCORE_LESS;

        wr_here = tok_valid_in && !tok_in.wr_done && (tok_in.wr_left == '0);

        tok_next          = tok_in;
        tok_next.sum      = mwu_pkg::sat_add(tok_in.sum, score);
        tok_next.wr_done  = tok_in.wr_done || wr_here;
        if (tok_in.opp_left != '0)
            tok_next.opp_left = tok_in.opp_left - 1'b1;
        if (tok_in.wr_left != '0)
            tok_next.wr_left = tok_in.wr_left - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= tok_valid_in;
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (wr_here && !tok_in.second)
            first_val_reg <= tok_in.key;
        if (wr_here && tok_in.second)
            second_val_reg <= tok_in.key;
    end

    assign tok_valid_out = valid_reg;
    assign tok_out       = tok_reg;

endmodule

// ===== rtl/mwu_ctrl.sv =====
// set control: group counts, running sum, drop flag, token launch and the
// result register; depends on mwu_pkg, the channel interfaces and the defines
`include "mann_whitney_u_statistic_core_defines.svh"

module mwu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    mwu_sample_if.sink          samples,
    mwu_result_if.source        results,
    output logic                launch_valid,
    output mwu_pkg::token_t     launch_tok,
    input  logic                exit_valid,
    input  mwu_pkg::token_t     exit_tok
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [mwu_pkg::CNT_W-1:0]  first_cnt_reg, first_cnt_next;
    logic [mwu_pkg::CNT_W-1:0]  second_cnt_reg, second_cnt_next;
    logic [mwu_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic                       dropped_reg, dropped_next;
    logic                       last_reg, last_next;
    logic                       launch_reg, launch_next;
    mwu_pkg::token_t            tok_reg, tok_next;
    logic                       out_valid_reg, out_valid_next;
    logic [mwu_pkg::SUM_W-1:0]  u_reg;
    logic [mwu_pkg::SIZE_W-1:0] first_size_reg;
    logic [mwu_pkg::SIZE_W-1:0] second_size_reg;
    logic                       overflow_reg;
    logic                       accept;
    logic                       full;
    logic                       load_out;

    assign samples.ready = (state_reg == ST_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign full          = samples.group
                         ? (second_cnt_reg >= mwu_pkg::CNT_W'(mwu_pkg::MAX_SECOND))
                         : (first_cnt_reg >= mwu_pkg::CNT_W'(mwu_pkg::MAX_FIRST));
    assign load_out      = (state_reg == ST_DONE) && last_reg
                         && (!out_valid_reg || results.ready);

    always_comb
    begin
        state_next      = state_reg;
        first_cnt_next  = first_cnt_reg;
        second_cnt_next = second_cnt_reg;
        sum_next        = sum_reg;
        dropped_next    = dropped_reg;
        last_next       = last_reg;
        launch_next     = 1'b0;
        tok_next        = tok_reg;
        out_valid_next  = out_valid_reg && !results.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_next = samples.last;
                    if (full)
                    begin
                        dropped_next = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        launch_next      = 1'b1;
                        tok_next.second  = samples.group;
                        tok_next.key     = samples.sample_value;
                        tok_next.opp_left = samples.group ? first_cnt_reg : second_cnt_reg;
                        tok_next.wr_left = samples.group ? second_cnt_reg : first_cnt_reg;
                        tok_next.wr_done = 1'b0;
                        tok_next.sum     = sum_reg;
                        if (samples.group)
                            second_cnt_next = second_cnt_reg + 1'b1;
                        else
                            first_cnt_next = first_cnt_reg + 1'b1;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (exit_valid)
                begin
                    sum_next   = exit_tok.sum;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!last_reg)
                    state_next = ST_IDLE;
                else if (load_out)
                begin
                    out_valid_next  = 1'b1;
                    first_cnt_next  = '0;
                    second_cnt_next = '0;
                    sum_next        = '0;
                    dropped_next    = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            sum_reg        <= '0;
            dropped_reg    <= 1'b0;
            last_reg       <= 1'b0;
            launch_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_cnt_reg  <= first_cnt_next;
            second_cnt_reg <= second_cnt_next;
            sum_reg        <= sum_next;
            dropped_reg    <= dropped_next;
            last_reg       <= last_next;
            launch_reg     <= launch_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        if (load_out)
        begin
            u_reg           <= sum_reg;
            first_size_reg  <= mwu_pkg::sat_size(first_cnt_reg);
            second_size_reg <= mwu_pkg::sat_size(second_cnt_reg);
            overflow_reg    <= dropped_reg;
        end
    end

    assign launch_valid        = launch_reg;
    assign launch_tok          = tok_reg;
    assign results.valid       = out_valid_reg;
    assign results.u_doubled   = u_reg;
    assign results.first_size  = first_size_reg;
    assign results.second_size = second_size_reg;
    assign results.overflow    = overflow_reg;

    // the chain only returns a token while one is in flight
    `MWU_ASSERT_NOW(a_exit_in_run, exit_valid, state_reg == ST_RUN)
    // a launch always leaves the controller waiting on the chain
    `MWU_ASSERT_NOW(a_launch_run, launch_reg, state_reg == ST_RUN)
    // a new result is only loaded from the done state
    `MWU_ASSERT_NOW(a_load_done, $rose(out_valid_reg), $past(state_reg) == ST_DONE)
    // group counts stay within their stores
    `MWU_ASSERT_NOW(a_cnt_bound, 1'b1,
        (first_cnt_reg <= mwu_pkg::CNT_W'(mwu_pkg::MAX_FIRST))
        && (second_cnt_reg <= mwu_pkg::CNT_W'(mwu_pkg::MAX_SECOND)))

endmodule
